// ----- hdl/sd_card_spi_host_sequencer_macros.svh -----
// Assertion macros shared by the sequencer RTL.
`ifndef SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SDS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, with no reset term.
`define SDS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hdl/sds_pkg.sv -----
// Package with the SD-card SPI sequencer types, codes and constants.
package sds_pkg;
  localparam int unsigned BlockBytes = 512;
  localparam int unsigned WakeBytes  = 10;

  localparam logic [2:0] CmdInit  = 3'd0;
  localparam logic [2:0] CmdRead  = 3'd1;
  localparam logic [2:0] CmdWrite = 3'd2;
  localparam logic [2:0] CmdErase = 3'd3;
  localparam logic [2:0] CmdByte  = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StComm    = 3'd1;
  localparam logic [2:0] StVolt    = 3'd2;
  localparam logic [2:0] StUnknown = 3'd3;
  localparam logic [2:0] StTimeout = 3'd4;
  localparam logic [2:0] StR1Err   = 3'd5;

  localparam logic [2:0] CtUnknown = 3'd0;
  localparam logic [2:0] CtMmc     = 3'd1;
  localparam logic [2:0] CtSdV1    = 3'd2;
  localparam logic [2:0] CtSdV2    = 3'd3;
  localparam logic [2:0] CtSdhc    = 3'd4;

  localparam logic [7:0] OpGoIdle  = 8'h40;
  localparam logic [7:0] OpMmcOp   = 8'h41;
  localparam logic [7:0] OpIfCond  = 8'h48;
  localparam logic [7:0] OpRdOne   = 8'h51;
  localparam logic [7:0] OpWrOne   = 8'h58;
  localparam logic [7:0] OpErStart = 8'h60;
  localparam logic [7:0] OpErEnd   = 8'h61;
  localparam logic [7:0] OpErDo    = 8'h66;
  localparam logic [7:0] OpAppOp   = 8'h69;
  localparam logic [7:0] OpApp     = 8'h77;
  localparam logic [7:0] OpGetOcr  = 8'h7A;

  localparam logic [7:0]  ByteIdle   = 8'hFF;
  localparam logic [7:0]  TokenStart = 8'hFE;
  localparam logic [7:0]  TokenMulti = 8'hFC;
  localparam logic [7:0]  CrcGoIdle  = 8'h95;
  localparam logic [7:0]  CrcIfCond  = 8'h87;
  localparam logic [7:0]  CheckPat   = 8'hAA;
  localparam logic [31:0] IfCondArg  = 32'h0000_01AA;
  localparam logic [31:0] HcsArg     = 32'h4000_0000;

  localparam logic [1:0] RegVmask = 2'd0;
  localparam logic [1:0] RegReady = 2'd1;
  localparam logic [1:0] RegRetry = 2'd2;
  localparam logic [1:0] RegToken = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic       exchange_request;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       write_data_wanted;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] r1_value;
    logic [2:0] card_type;
    logic       busy_res;
  } out_item_t;
endpackage

// ----- hdl/sds_stream_if.sv -----
// Valid/ready channel interface carrying one payload type.
interface sds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sd_card_spi_host_sequencer.sv -----
// SD-card SPI-mode host sequencer: init, single-block read, write and erase.
// Each accepted input item is one transfer that is decoded by the state machine in the
// same cycle and produces exactly one result transfer, registered at the output; a new
// item is accepted every cycle while the output register is empty or being drained,
// so the block sustains one item per clock. Configuration registers sit on an APB port
// at byte addresses 0, 4, 8 and 12 and are written without wait states.
`include "sd_card_spi_host_sequencer_macros.svh"
module sd_card_spi_host_sequencer #(
  parameter int unsigned BLOCK_BYTES = sds_pkg::BlockBytes,
  parameter int unsigned WAKE_BYTES  = sds_pkg::WakeBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sds_stream_if.sink   in_if,
  sds_stream_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IdxW = (BLOCK_BYTES > WAKE_BYTES) ? $clog2(BLOCK_BYTES + 1)
                                                            : $clog2(WAKE_BYTES + 1);
  localparam logic [IdxW-1:0] LastBlk  = IdxW'(BLOCK_BYTES - 1);
  localparam logic [IdxW-1:0] LastWake = IdxW'(WAKE_BYTES - 1);

  typedef enum logic [3:0] {
    PhIdle, PhWake, PhReady, PhSend, PhR1, PhExtra, PhToken,
    PhRdata, PhRcrc, PhWgap, PhWtoken, PhWdata, PhWpad
  } phase_e;

  typedef enum logic [4:0] {
    SgNone, SgWake0, SgCmd0, SgCmd8, SgV1Ocr, SgV1App, SgV1Op, SgMmcWake, SgMmcLoop,
    SgV1Lapp, SgV1Lop, SgV2Ocr, SgV2Wake, SgV2Lapp, SgV2Lop, SgV2Ccs, SgRd, SgWr,
    SgEr1, SgEr2, SgEr3
  } stage_e;

  logic [31:0] vmask_q;
  logic [15:0] rlim_q, tlim_q;
  logic [7:0]  ilim_q;

  phase_e      phase_q, phase_d;
  stage_e      stage_q, stage_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0] poll_q, poll_d;
  logic [7:0]  retry_q, retry_d;
  logic [7:0]  r1_q, r1_d;
  logic [31:0] low_q, low_d;
  logic [7:0]  cmdb_q, cmdb_d;
  logic [31:0] arg_q, arg_d;
  logic [2:0]  ctype_q, ctype_d;
  logic        sel_q, sel_d;
  logic [7:0]  ltx_q, ltx_d;
  logic        lwant_q, lwant_d;

  sds_pkg::out_item_t res;
  sds_pkg::out_item_t out_q;
  logic out_vld_q;
  logic take;

  assign pready = 1'b1;
  assign in_if.ready = !out_vld_q || out_if.ready;
  assign take = in_if.valid && in_if.ready;
  assign out_if.valid = out_vld_q;
  assign out_if.data = out_q;

  always_comb begin
    unique case (paddr[3:2])
      sds_pkg::RegVmask: prdata = vmask_q;
      sds_pkg::RegReady: prdata = {16'd0, rlim_q};
      sds_pkg::RegRetry: prdata = {24'd0, ilim_q};
      sds_pkg::RegToken: prdata = {16'd0, tlim_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmask_q <= 32'h0010_0000;
      rlim_q  <= 16'd10000;
      ilim_q  <= 8'd200;
      tlim_q  <= 16'd10000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        sds_pkg::RegVmask: vmask_q <= pwdata;
        sds_pkg::RegReady: rlim_q <= pwdata[15:0];
        sds_pkg::RegRetry: ilim_q <= pwdata[7:0];
        sds_pkg::RegToken: tlim_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0]  cmd;
    logic [7:0]  rx;
    logic [7:0]  crc;
    logic [7:0]  rtmp;
    logic [IdxW-1:0] nxt;
    logic        do_after_wake, do_after_cmd;
    logic        do_issue, do_wake, do_fin;
    logic [7:0]  iss_op;
    logic [31:0] iss_arg;
    logic [2:0]  fin_st;
    logic        e_req;
    logic [7:0]  e_tx;
    logic        e_want;
    logic [1:0]  chk;
    cmd = in_if.data.command;
    rx = in_if.data.rx_byte;
    nxt = idx_q + 1'b1;
    phase_d = phase_q; stage_d = stage_q; idx_d = idx_q; poll_d = poll_q;
    retry_d = retry_q; r1_d = r1_q; low_d = low_q; cmdb_d = cmdb_q; arg_d = arg_q;
    ctype_d = ctype_q; sel_d = sel_q; ltx_d = ltx_q; lwant_d = lwant_q;
    res = '0;
    do_after_wake = 1'b0; do_after_cmd = 1'b0; do_issue = 1'b0; do_wake = 1'b0;
    do_fin = 1'b0; iss_op = '0; iss_arg = '0; fin_st = sds_pkg::StOk;
    e_req = 1'b0; e_tx = '0; e_want = 1'b0; chk = 2'd0;
    rtmp = retry_q - 8'd1;
    crc = (cmdb_q == sds_pkg::OpGoIdle) ? sds_pkg::CrcGoIdle :
          (cmdb_q == sds_pkg::OpIfCond) ? sds_pkg::CrcIfCond : sds_pkg::ByteIdle;

    if (phase_q != PhIdle) begin
      if (cmd == sds_pkg::CmdByte) begin
        unique case (phase_q)
          PhWake: begin
            if (idx_q != LastWake) begin
              idx_d = nxt; e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
            end else do_after_wake = 1'b1;
          end
          PhReady: begin
            if (poll_q >= rlim_q) begin
              do_fin = 1'b1; fin_st = sds_pkg::StComm;
            end else begin
              poll_d = poll_q + 16'd1; e_req = 1'b1;
              if (rx == sds_pkg::ByteIdle) begin
                phase_d = PhSend; idx_d = '0; e_tx = cmdb_q;
              end else e_tx = sds_pkg::ByteIdle;
            end
          end
          PhSend: begin
            e_req = 1'b1;
            idx_d = nxt;
            case (idx_q[2:0])
              3'd0: e_tx = arg_q[31:24];
              3'd1: e_tx = arg_q[23:16];
              3'd2: e_tx = arg_q[15:8];
              3'd3: e_tx = arg_q[7:0];
              3'd4: e_tx = crc;
              default: begin
                e_tx = sds_pkg::ByteIdle; phase_d = PhR1; poll_d = '0; idx_d = idx_q;
              end
            endcase
          end
          PhR1: begin
            if (poll_q >= rlim_q) begin
              do_fin = 1'b1; fin_st = sds_pkg::StComm;
            end else begin
              poll_d = poll_q + 16'd1;
              if (rx == sds_pkg::ByteIdle) begin
                e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
              end else begin
                r1_d = rx;
                if (cmdb_q == sds_pkg::OpIfCond || cmdb_q == sds_pkg::OpGetOcr) begin
                  phase_d = PhExtra; idx_d = '0; e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
                end else do_after_cmd = 1'b1;
              end
            end
          end
          PhExtra: begin
            low_d = {low_q[23:0], rx};
            if (idx_q[1:0] != 2'd3) begin
              idx_d = nxt; e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
            end else do_after_cmd = 1'b1;
          end
          PhToken: begin
            if (poll_q >= tlim_q) begin
              do_fin = 1'b1; fin_st = sds_pkg::StTimeout;
            end else begin
              poll_d = poll_q + 16'd1;
              if (rx == sds_pkg::TokenStart || rx == sds_pkg::TokenMulti) begin
                phase_d = PhRdata; idx_d = '0;
              end
              e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
            end
          end
          PhRdata: begin
            res.read_valid = 1'b1; res.read_byte = rx;
            if (idx_q != LastBlk) idx_d = nxt;
            else begin
              phase_d = PhRcrc; idx_d = '0;
            end
            e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
          end
          PhRcrc: begin
            if (idx_q[0] == 1'b0) begin
              idx_d = nxt; e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
            end else begin
              do_fin = 1'b1; fin_st = sds_pkg::StOk;
            end
          end
          PhWgap: begin
            phase_d = PhWtoken; e_req = 1'b1; e_tx = sds_pkg::TokenStart; e_want = 1'b1;
          end
          PhWtoken: begin
            phase_d = PhWdata; idx_d = '0; e_req = 1'b1;
            e_tx = in_if.data.write_byte; e_want = (BLOCK_BYTES > 1);
          end
          PhWdata: begin
            e_req = 1'b1;
            if (idx_q != LastBlk) begin
              idx_d = nxt; e_tx = in_if.data.write_byte; e_want = (nxt != LastBlk);
            end else begin
              phase_d = PhWpad; idx_d = '0; e_tx = sds_pkg::ByteIdle;
            end
          end
          PhWpad: begin
            if (idx_q[1:0] != 2'd3) begin
              idx_d = nxt; e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
            end else begin
              do_fin = 1'b1; fin_st = sds_pkg::StOk;
            end
          end
          default: begin
            do_fin = 1'b1; fin_st = sds_pkg::StComm;
          end
        endcase
      end else begin
        res.exchange_request = 1'b1; res.tx_byte = ltx_q;
        res.write_data_wanted = lwant_q; res.select_active = sel_q;
      end
    end else begin
      case (cmd)
        sds_pkg::CmdInit: begin
          sel_d = 1'b0; stage_d = SgWake0; do_wake = 1'b1;
        end
        sds_pkg::CmdRead: begin
          sel_d = 1'b1; stage_d = SgRd; do_issue = 1'b1;
          iss_op = sds_pkg::OpRdOne; iss_arg = in_if.data.address;
        end
        sds_pkg::CmdWrite: begin
          sel_d = 1'b1; stage_d = SgWr; do_issue = 1'b1;
          iss_op = sds_pkg::OpWrOne; iss_arg = in_if.data.address;
        end
        sds_pkg::CmdErase: begin
          sel_d = 1'b1; stage_d = SgEr1; do_issue = 1'b1;
          iss_op = sds_pkg::OpErStart; iss_arg = in_if.data.address;
        end
        default: ;
      endcase
    end

    // chk: 1 MMC check, 2 SDv1 check, 3 SDv2 check.
    if (do_after_wake) begin
      unique case (stage_q)
        SgWake0: begin
          sel_d = 1'b1; stage_d = SgCmd0; do_issue = 1'b1; iss_op = sds_pkg::OpGoIdle;
        end
        SgMmcWake: chk = 2'd1;
        SgV2Wake:  chk = 2'd3;
        default: begin
          do_fin = 1'b1; fin_st = sds_pkg::StComm;
        end
      endcase
    end
    if (do_after_cmd) begin
      unique case (stage_q)
        SgCmd0: begin
          stage_d = SgCmd8; do_issue = 1'b1;
          iss_op = sds_pkg::OpIfCond; iss_arg = sds_pkg::IfCondArg;
        end
        SgCmd8: begin
          if (r1_d[2]) begin
            stage_d = SgV1Ocr; do_issue = 1'b1; iss_op = sds_pkg::OpGetOcr;
          end else if (low_d[7:0] != sds_pkg::CheckPat) begin
            do_fin = 1'b1; fin_st = sds_pkg::StComm;
          end else begin
            stage_d = SgV2Ocr; do_issue = 1'b1; iss_op = sds_pkg::OpGetOcr;
          end
        end
        SgV1Ocr: begin
          if ((vmask_q & low_d) == '0) begin
            do_fin = 1'b1; fin_st = sds_pkg::StVolt;
          end else if (r1_d[2]) begin
            do_fin = 1'b1; fin_st = sds_pkg::StUnknown;
          end else begin
            retry_d = ilim_q; stage_d = SgV1App; do_issue = 1'b1; iss_op = sds_pkg::OpApp;
          end
        end
        SgV1App, SgV1Lapp, SgV2Lapp: begin
          stage_d = (stage_q == SgV1App) ? SgV1Op :
                    (stage_q == SgV1Lapp) ? SgV1Lop : SgV2Lop;
          do_issue = 1'b1; iss_op = sds_pkg::OpAppOp; iss_arg = sds_pkg::HcsArg;
        end
        SgV1Op: begin
          if (r1_d[2]) begin
            stage_d = SgMmcWake; do_wake = 1'b1;
          end else chk = 2'd2;
        end
        SgMmcLoop, SgV1Lop, SgV2Lop: begin
          retry_d = rtmp;
          if (rtmp == 8'd0) begin
            do_fin = 1'b1; fin_st = sds_pkg::StTimeout;
          end else chk = (stage_q == SgMmcLoop) ? 2'd1 :
                         (stage_q == SgV1Lop) ? 2'd2 : 2'd3;
        end
        SgV2Ocr: begin
          if ((vmask_q & low_d) == '0) begin
            do_fin = 1'b1; fin_st = sds_pkg::StVolt;
          end else begin
            retry_d = ilim_q; stage_d = SgV2Wake; do_wake = 1'b1;
          end
        end
        SgV2Ccs: begin
          ctype_d = low_d[30] ? sds_pkg::CtSdhc : sds_pkg::CtSdV2;
          do_fin = 1'b1; fin_st = sds_pkg::StOk;
        end
        SgRd, SgWr: begin
          if (r1_d != 8'd0) begin
            do_fin = 1'b1; fin_st = sds_pkg::StR1Err;
          end else begin
            phase_d = (stage_q == SgRd) ? PhToken : PhWgap;
            if (stage_q == SgRd) poll_d = '0;
            e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
          end
        end
        SgEr1, SgEr2: begin
          if (r1_d != 8'd0) begin
            do_fin = 1'b1; fin_st = sds_pkg::StR1Err;
          end else if (stage_q == SgEr1) begin
            stage_d = SgEr2; do_issue = 1'b1; iss_op = sds_pkg::OpErEnd; iss_arg = arg_q;
          end else begin
            stage_d = SgEr3; do_issue = 1'b1; iss_op = sds_pkg::OpErDo;
          end
        end
        SgEr3: begin
          do_fin = 1'b1; fin_st = sds_pkg::StOk;
        end
        default: begin
          do_fin = 1'b1; fin_st = sds_pkg::StComm;
        end
      endcase
    end
    if (chk != 2'd0) begin
      if (r1_d[0]) begin
        do_issue = 1'b1;
        unique case (chk)
          2'd1: begin
            stage_d = SgMmcLoop; iss_op = sds_pkg::OpMmcOp;
          end
          2'd2: begin
            stage_d = SgV1Lapp; iss_op = sds_pkg::OpApp;
          end
          default: begin
            stage_d = SgV2Lapp; iss_op = sds_pkg::OpApp;
          end
        endcase
      end else if (chk == 2'd3) begin
        do_issue = 1'b1; stage_d = SgV2Ccs; iss_op = sds_pkg::OpGetOcr;
      end else begin
        ctype_d = (chk == 2'd1) ? sds_pkg::CtMmc : sds_pkg::CtSdV1;
        do_fin = 1'b1; fin_st = sds_pkg::StOk;
      end
    end
    if (do_issue) begin
      cmdb_d = iss_op; arg_d = iss_arg; phase_d = PhReady; poll_d = '0;
      e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
    end
    if (do_wake) begin
      phase_d = PhWake; idx_d = '0; e_req = 1'b1; e_tx = sds_pkg::ByteIdle;
    end
    if (e_req) begin
      res.exchange_request = 1'b1; res.tx_byte = e_tx;
      res.write_data_wanted = e_want; res.select_active = sel_d;
      ltx_d = e_tx; lwant_d = e_want;
    end
    if (do_fin) begin
      phase_d = PhIdle; stage_d = SgNone; sel_d = 1'b0;
      res.done_res = 1'b1; res.status = fin_st;
    end
    res.r1_value = r1_d;
    res.card_type = ctype_d;
    res.busy_res = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; stage_q <= SgNone; idx_q <= '0; poll_q <= '0;
      retry_q <= '0; r1_q <= '0; low_q <= '0; cmdb_q <= '0; arg_q <= '0;
      ctype_q <= sds_pkg::CtUnknown; sel_q <= 1'b0; ltx_q <= '0; lwant_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; stage_q <= stage_d; idx_q <= idx_d; poll_q <= poll_d;
        retry_q <= retry_d; r1_q <= r1_d; low_q <= low_d; cmdb_q <= cmdb_d;
        arg_q <= arg_d; ctype_q <= ctype_d; sel_q <= sel_d; ltx_q <= ltx_d;
        lwant_q <= lwant_d;
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= res;
  end

  `SDS_ASSERT(a_busy_phase, clk_i, rst_ni, take |=> (out_q.busy_res == (phase_q != PhIdle)), "busy result disagrees with phase")
  `SDS_ASSERT(a_done_idle, clk_i, rst_ni, (take && res.done_res) |=> (phase_q == PhIdle && !sel_q), "finished operation left chip select or phase active")
  `SDS_ASSERT(a_done_no_req, clk_i, rst_ni, (out_vld_q && out_q.done_res) |-> !out_q.exchange_request, "done result also requests an exchange")
  `SDS_ASSERT(a_stall_hold, clk_i, rst_ni, (out_vld_q && !out_if.ready) |=> (out_vld_q && $stable(out_q)), "stalled result changed")
endmodule

// ----- test/tb_sd_card_spi_host_sequencer.sv -----
// Testbench for the SD-card SPI host sequencer: emulated card, predictor and result checks.
module tb_sd_card_spi_host_sequencer;

  typedef enum int {
    PhIdle, PhWake, PhReady, PhSend, PhR1, PhExtra, PhToken,
    PhRData, PhRCrc, PhWGap, PhWToken, PhWData, PhWPad
  } phase_e;

  typedef enum int {
    SgNone, SgWake0, SgCmd0, SgCmd8, SgV1Ocr, SgV1App, SgV1Op, SgMmcWake,
    SgMmcLoop, SgV1LApp, SgV1LOp, SgV2Ocr, SgV2Wake, SgV2LApp, SgV2LOp,
    SgV2Ccs, SgRd, SgWr, SgEr1, SgEr2, SgEr3
  } stage_e;

  typedef enum int { CardSdV2, CardSdV1, CardMmc, CardStuck } card_e;

  localparam logic [7:0] R1Idle    = 8'h01;
  localparam logic [7:0] R1Illegal = 8'h04;

  class sds_scoreboard;
    logic [31:0] vmask = 32'h0010_0000;
    logic [15:0] ready_lim = 16'd10000;
    logic [7:0]  retry_lim = 8'd200;
    logic [15:0] token_lim = 16'd10000;
    phase_e      ph = PhIdle;
    stage_e      sg = SgNone;
    logic [7:0]  retries = '0, cmd_byte = '0, last_tx = '0;
    logic [2:0]  ctype = sds_pkg::CtUnknown;
    int          idx = 0;
    logic [15:0] polls = '0;
    logic [39:0] resp = '0;
    logic [31:0] arg = '0;
    logic        sel = 1'b0, last_want = 1'b0;
    sds_pkg::out_item_t o;
    sds_pkg::out_item_t pending[$];
    bit          failed = 0;

    function void emit(logic [7:0] tx, logic want);
      o.exchange_request = 1'b1;
      o.tx_byte = tx;
      o.write_data_wanted = want;
      o.select_active = sel;
      last_tx = tx;
      last_want = want;
    endfunction

    function void finish(logic [2:0] st);
      ph = PhIdle;
      sg = SgNone;
      sel = 1'b0;
      o.exchange_request = 1'b0;
      o.tx_byte = '0;
      o.write_data_wanted = 1'b0;
      o.select_active = 1'b0;
      o.done_res = 1'b1;
      o.status = st;
    endfunction

    function void issue(logic [7:0] op, logic [31:0] a);
      cmd_byte = op;
      arg = a;
      ph = PhReady;
      polls = '0;
      emit(sds_pkg::ByteIdle, 1'b0);
    endfunction

    function void start_wake();
      ph = PhWake;
      idx = 0;
      emit(sds_pkg::ByteIdle, 1'b0);
    endfunction

    function logic [7:0] frame_crc();
      if (cmd_byte == sds_pkg::OpGoIdle) return sds_pkg::CrcGoIdle;
      if (cmd_byte == sds_pkg::OpIfCond) return sds_pkg::CrcIfCond;
      return sds_pkg::ByteIdle;
    endfunction

    function bit retry_spent();
      retries = retries - 8'd1;
      return retries == 8'd0;
    endfunction

    function void mmc_check();
      if ((resp[39:32] & R1Idle) != 0) begin
        sg = SgMmcLoop;
        issue(sds_pkg::OpMmcOp, '0);
      end else begin
        ctype = sds_pkg::CtMmc;
        finish(sds_pkg::StOk);
      end
    endfunction

    function void v1_check();
      if ((resp[39:32] & R1Idle) != 0) begin
        sg = SgV1LApp;
        issue(sds_pkg::OpApp, '0);
      end else begin
        ctype = sds_pkg::CtSdV1;
        finish(sds_pkg::StOk);
      end
    endfunction

    function void v2_check();
      if ((resp[39:32] & R1Idle) != 0) begin
        sg = SgV2LApp;
        issue(sds_pkg::OpApp, '0);
      end else begin
        sg = SgV2Ccs;
        issue(sds_pkg::OpGetOcr, '0);
      end
    endfunction

    function void after_wake();
      case (sg)
        SgWake0: begin
          sel = 1'b1;
          sg = SgCmd0;
          issue(sds_pkg::OpGoIdle, '0);
        end
        SgMmcWake: mmc_check();
        SgV2Wake: v2_check();
        default: finish(sds_pkg::StComm);
      endcase
    endfunction

    function void after_command();
      logic [7:0]  r1;
      logic [31:0] low;
      r1 = resp[39:32];
      low = resp[31:0];
      case (sg)
        SgCmd0: begin
          sg = SgCmd8;
          issue(sds_pkg::OpIfCond, sds_pkg::IfCondArg);
        end
        SgCmd8: begin
          if ((r1 & R1Illegal) != 0) begin
            sg = SgV1Ocr;
            issue(sds_pkg::OpGetOcr, '0);
          end else if (low[7:0] != sds_pkg::CheckPat) begin
            finish(sds_pkg::StComm);
          end else begin
            sg = SgV2Ocr;
            issue(sds_pkg::OpGetOcr, '0);
          end
        end
        SgV1Ocr: begin
          if ((vmask & low) == 0) finish(sds_pkg::StVolt);
          else if ((r1 & R1Illegal) != 0) finish(sds_pkg::StUnknown);
          else begin
            retries = retry_lim;
            sg = SgV1App;
            issue(sds_pkg::OpApp, '0);
          end
        end
        SgV1App: begin
          sg = SgV1Op;
          issue(sds_pkg::OpAppOp, sds_pkg::HcsArg);
        end
        SgV1Op: begin
          if ((r1 & R1Illegal) != 0) begin
            sg = SgMmcWake;
            start_wake();
          end else v1_check();
        end
        SgMmcLoop: if (retry_spent()) finish(sds_pkg::StTimeout); else mmc_check();
        SgV1LApp: begin
          sg = SgV1LOp;
          issue(sds_pkg::OpAppOp, sds_pkg::HcsArg);
        end
        SgV1LOp: if (retry_spent()) finish(sds_pkg::StTimeout); else v1_check();
        SgV2Ocr: begin
          if ((vmask & low) == 0) finish(sds_pkg::StVolt);
          else begin
            retries = retry_lim;
            sg = SgV2Wake;
            start_wake();
          end
        end
        SgV2LApp: begin
          sg = SgV2LOp;
          issue(sds_pkg::OpAppOp, sds_pkg::HcsArg);
        end
        SgV2LOp: if (retry_spent()) finish(sds_pkg::StTimeout); else v2_check();
        SgV2Ccs: begin
          ctype = low[30] ? sds_pkg::CtSdhc : sds_pkg::CtSdV2;
          finish(sds_pkg::StOk);
        end
        SgRd: begin
          if (r1 != 0) finish(sds_pkg::StR1Err);
          else begin
            ph = PhToken;
            polls = '0;
            emit(sds_pkg::ByteIdle, 1'b0);
          end
        end
        SgWr: begin
          if (r1 != 0) finish(sds_pkg::StR1Err);
          else begin
            ph = PhWGap;
            emit(sds_pkg::ByteIdle, 1'b0);
          end
        end
        SgEr1: begin
          if (r1 != 0) finish(sds_pkg::StR1Err);
          else begin
            sg = SgEr2;
            issue(sds_pkg::OpErEnd, arg);
          end
        end
        SgEr2: begin
          if (r1 != 0) finish(sds_pkg::StR1Err);
          else begin
            sg = SgEr3;
            issue(sds_pkg::OpErDo, '0);
          end
        end
        SgEr3: finish(sds_pkg::StOk);
        default: finish(sds_pkg::StComm);
      endcase
    endfunction

    function void byte_done(logic [7:0] rx, logic [7:0] wb);
      int nxt;
      nxt = idx + 1;
      case (ph)
        PhWake: begin
          if (nxt < sds_pkg::WakeBytes) begin
            idx = nxt;
            emit(sds_pkg::ByteIdle, 1'b0);
          end else after_wake();
        end
        PhReady: begin
          if (polls >= ready_lim) finish(sds_pkg::StComm);
          else begin
            polls++;
            if (rx == sds_pkg::ByteIdle) begin
              ph = PhSend;
              idx = 0;
              emit(cmd_byte, 1'b0);
            end else emit(sds_pkg::ByteIdle, 1'b0);
          end
        end
        PhSend: begin
          if (nxt <= 4) begin
            idx = nxt;
            emit(8'(arg >> (8 * (4 - nxt))), 1'b0);
          end else if (nxt == 5) begin
            idx = 5;
            emit(frame_crc(), 1'b0);
          end else begin
            ph = PhR1;
            polls = '0;
            emit(sds_pkg::ByteIdle, 1'b0);
          end
        end
        PhR1: begin
          if (polls >= ready_lim) finish(sds_pkg::StComm);
          else begin
            polls++;
            if (rx == sds_pkg::ByteIdle) emit(sds_pkg::ByteIdle, 1'b0);
            else begin
              resp[39:32] = rx;
              if (cmd_byte == sds_pkg::OpIfCond || cmd_byte == sds_pkg::OpGetOcr) begin
                ph = PhExtra;
                idx = 0;
                emit(sds_pkg::ByteIdle, 1'b0);
              end else after_command();
            end
          end
        end
        PhExtra: begin
          resp[31:0] = {resp[23:0], rx};
          if (nxt < 4) begin
            idx = nxt;
            emit(sds_pkg::ByteIdle, 1'b0);
          end else after_command();
        end
        PhToken: begin
          if (polls >= token_lim) finish(sds_pkg::StTimeout);
          else begin
            polls++;
            if (rx == sds_pkg::TokenStart || rx == sds_pkg::TokenMulti) begin
              ph = PhRData;
              idx = 0;
            end
            emit(sds_pkg::ByteIdle, 1'b0);
          end
        end
        PhRData: begin
          o.read_valid = 1'b1;
          o.read_byte = rx;
          if (nxt < sds_pkg::BlockBytes) idx = nxt;
          else begin
            ph = PhRCrc;
            idx = 0;
          end
          emit(sds_pkg::ByteIdle, 1'b0);
        end
        PhRCrc: begin
          if (nxt < 2) begin
            idx = nxt;
            emit(sds_pkg::ByteIdle, 1'b0);
          end else finish(sds_pkg::StOk);
        end
        PhWGap: begin
          ph = PhWToken;
          emit(sds_pkg::TokenStart, 1'b1);
        end
        PhWToken: begin
          ph = PhWData;
          idx = 0;
          emit(wb, 1 < sds_pkg::BlockBytes);
        end
        PhWData: begin
          if (nxt < sds_pkg::BlockBytes) begin
            idx = nxt;
            emit(wb, nxt + 1 < sds_pkg::BlockBytes);
          end else begin
            ph = PhWPad;
            idx = 0;
            emit(sds_pkg::ByteIdle, 1'b0);
          end
        end
        PhWPad: begin
          if (nxt < 4) begin
            idx = nxt;
            emit(sds_pkg::ByteIdle, 1'b0);
          end else finish(sds_pkg::StOk);
        end
        default: finish(sds_pkg::StComm);
      endcase
    endfunction

    function void note(sds_pkg::in_item_t it);
      o = '0;
      if (ph != PhIdle) begin
        if (it.command == sds_pkg::CmdByte) byte_done(it.rx_byte, it.write_byte);
        else begin
          o.exchange_request = 1'b1;
          o.tx_byte = last_tx;
          o.write_data_wanted = last_want;
          o.select_active = sel;
        end
      end else begin
        case (it.command)
          sds_pkg::CmdInit: begin
            sel = 1'b0;
            sg = SgWake0;
            start_wake();
          end
          sds_pkg::CmdRead: begin
            sel = 1'b1;
            sg = SgRd;
            issue(sds_pkg::OpRdOne, it.address);
          end
          sds_pkg::CmdWrite: begin
            sel = 1'b1;
            sg = SgWr;
            issue(sds_pkg::OpWrOne, it.address);
          end
          sds_pkg::CmdErase: begin
            sel = 1'b1;
            sg = SgEr1;
            issue(sds_pkg::OpErStart, it.address);
          end
          default: ;
        endcase
      end
      o.r1_value = resp[39:32];
      o.card_type = ctype;
      o.busy_res = (ph != PhIdle);
      pending.push_back(o);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        failed = 1;
      end
    endfunction

    function void check(sds_pkg::out_item_t a);
      sds_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, a);
        failed = 1;
        return;
      end
      e = pending.pop_front();
      cmp_field("exchange_request", 8'(e.exchange_request), 8'(a.exchange_request));
      cmp_field("tx_byte", e.tx_byte, a.tx_byte);
      cmp_field("select_active", 8'(e.select_active), 8'(a.select_active));
      cmp_field("write_data_wanted", 8'(e.write_data_wanted), 8'(a.write_data_wanted));
      cmp_field("read_valid", 8'(e.read_valid), 8'(a.read_valid));
      cmp_field("read_byte", e.read_byte, a.read_byte);
      cmp_field("done_res", 8'(e.done_res), 8'(a.done_res));
      cmp_field("status", 8'(e.status), 8'(a.status));
      cmp_field("r1_value", e.r1_value, a.r1_value);
      cmp_field("card_type", 8'(e.card_type), 8'(a.card_type));
      cmp_field("busy_res", 8'(e.busy_res), 8'(a.busy_res));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  bit          calm = 0;
  card_e       card = CardSdV2;
  sds_scoreboard sb = new();

  sds_stream_if #(.payload_t(sds_pkg::in_item_t))  in_if();
  sds_stream_if #(.payload_t(sds_pkg::out_item_t)) out_if();

  sd_card_spi_host_sequencer DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check(out_if.data);
    out_if.ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  function automatic logic [7:0] card_r1();
    case (sb.cmd_byte)
      sds_pkg::OpGoIdle: return R1Idle;
      sds_pkg::OpIfCond: return (card == CardSdV2) ? R1Idle : (R1Idle | R1Illegal);
      sds_pkg::OpApp:    return R1Idle;
      sds_pkg::OpAppOp: begin
        if (card == CardStuck) return R1Idle;
        if (card == CardMmc && sb.sg == SgV1Op) return R1Idle | R1Illegal;
        return $urandom_range(0, 1) ? R1Idle : 8'h00;
      end
      sds_pkg::OpMmcOp: return (card == CardStuck || $urandom_range(0, 1)) ? R1Idle : 8'h00;
      default:  return 8'h00;
    endcase
  endfunction

  function automatic sds_pkg::in_item_t next_item();
    sds_pkg::in_item_t it;
    int       r;
    r = $urandom_range(0, 7);
    it.address = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    it.rx_byte = 8'($urandom);
    it.write_byte = 8'($urandom);
    it.command = sds_pkg::CmdByte;
    r = $urandom_range(0, 99);
    if (sb.ph == PhIdle) begin
      if (r < 35) begin
        it.command = sds_pkg::CmdInit;
        card = card_e'($urandom_range(0, 3));
      end else if (r < 60) it.command = sds_pkg::CmdRead;
      else if (r < 80) it.command = sds_pkg::CmdWrite;
      else if (r < 95) it.command = sds_pkg::CmdErase;
      else it.command = 3'($urandom_range(4, 7));
    end else if (r < 4) begin
      it.command = 3'($urandom_range(5, 11));
    end else begin
      case (sb.ph)
        PhReady: if (r < 80) it.rx_byte = sds_pkg::ByteIdle;
        PhR1: begin
          if (r < 25) it.rx_byte = sds_pkg::ByteIdle;
          else if (r < 90) it.rx_byte = card_r1();
        end
        PhExtra: begin
          if (sb.cmd_byte == sds_pkg::OpIfCond) begin
            if (sb.idx == 3 && r < 90) it.rx_byte = sds_pkg::CheckPat;
          end else if (sb.idx != 0 && r < 70) it.rx_byte = sds_pkg::ByteIdle;
        end
        PhToken: begin
          if (r < 15) it.rx_byte = sds_pkg::TokenStart;
          else if (r < 30) it.rx_byte = sds_pkg::TokenMulti;
          else if (r < 80) it.rx_byte = sds_pkg::ByteIdle;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input sds_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 11);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(it);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sds_pkg::RegVmask: sb.vmask = value;
      sds_pkg::RegReady: sb.ready_lim = value[15:0];
      sds_pkg::RegRetry: sb.retry_lim = value[7:0];
      default:  sb.token_lim = value[15:0];
    endcase
  endtask

  task automatic run_items(input int count);
    int n;
    n = 0;
    while (n < count || sb.ph != PhIdle) begin
      send_item(next_item());
      n++;
    end
    settle();
  endtask

  initial begin
    sds_pkg::in_item_t it;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Items that an idle block ignores, with all-ones and all-zero fields.
    for (int c = 4; c < 8; c++) begin
      it = '1;
      it.command = 3'(c);
      send_item(it);
      it = '0;
      it.command = 3'(c);
      send_item(it);
    end
    settle();

    run_items(300);
    write_reg(sds_pkg::RegVmask, 32'h0);
    write_reg(sds_pkg::RegReady, 32'd1);
    write_reg(sds_pkg::RegRetry, 32'd1);
    write_reg(sds_pkg::RegToken, 32'd1);
    run_items(200);
    write_reg(sds_pkg::RegVmask, 32'hFFFF_FFFF);
    write_reg(sds_pkg::RegReady, 32'd65535);
    write_reg(sds_pkg::RegRetry, 32'd255);
    write_reg(sds_pkg::RegToken, 32'd65535);
    calm = 1;
    run_items(300);
    calm = 0;
    for (int p = 0; p < 3; p++) begin
      write_reg(sds_pkg::RegVmask, $urandom);
      write_reg(sds_pkg::RegReady, $urandom_range(2, 8));
      write_reg(sds_pkg::RegRetry, $urandom_range(1, 6));
      write_reg(sds_pkg::RegToken, $urandom_range(2, 8));
      run_items(250);
    end

    repeat (10) @(posedge clk_i);
    if (!sb.failed && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
